>>> rtl/aes_ctr_payload_crypt_core_macros.svh
// ----------------------------------------------------------------------------
// Assertion macros for the AES-CTR payload cipher
// Clocked concurrent assertions, disabled while reset is asserted.
// ----------------------------------------------------------------------------
`ifndef AES_CTR_PAYLOAD_CRYPT_CORE_MACROS_SVH
`define AES_CTR_PAYLOAD_CRYPT_CORE_MACROS_SVH

// antecedent in this cycle implies consequent in the next
`define ACPC_ASSERT_NEXT(lbl, clk, rst_n, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("acpc assertion failed");

// antecedent implies consequent in the same cycle
`define ACPC_ASSERT_SAME(lbl, clk, rst_n, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("acpc assertion failed");

`endif

>>> rtl/acpc_pkg.sv
// ----------------------------------------------------------------------------
// acpc_pkg
// Shared types, constants and AES-128 round functions.
// ----------------------------------------------------------------------------
package acpc_pkg;

  localparam int unsigned NumRows = 11;  // round key rows
  localparam int unsigned RowW    = 4;

  localparam logic REG_KEY_HIGH = 1'b0;
  localparam logic REG_KEY_LOW  = 1'b1;

  localparam logic [7:0] CTR_IN_START  = 8'd0;
  localparam logic [7:0] CTR_OUT_START = 8'd128;

  typedef struct packed {
    logic         start;
    logic [127:0] blk;
  } eng_req_t;

  typedef struct packed {
    logic         busy;
    logic         done;
    logic [127:0] result;
  } eng_rsp_t;

  localparam logic [7:0] SBOX [256] = '{
    8'h63,8'h7c,8'h77,8'h7b,8'hf2,8'h6b,8'h6f,8'hc5,8'h30,8'h01,8'h67,8'h2b,8'hfe,8'hd7,8'hab,8'h76,
    8'hca,8'h82,8'hc9,8'h7d,8'hfa,8'h59,8'h47,8'hf0,8'had,8'hd4,8'ha2,8'haf,8'h9c,8'ha4,8'h72,8'hc0,
    8'hb7,8'hfd,8'h93,8'h26,8'h36,8'h3f,8'hf7,8'hcc,8'h34,8'ha5,8'he5,8'hf1,8'h71,8'hd8,8'h31,8'h15,
    8'h04,8'hc7,8'h23,8'hc3,8'h18,8'h96,8'h05,8'h9a,8'h07,8'h12,8'h80,8'he2,8'heb,8'h27,8'hb2,8'h75,
    8'h09,8'h83,8'h2c,8'h1a,8'h1b,8'h6e,8'h5a,8'ha0,8'h52,8'h3b,8'hd6,8'hb3,8'h29,8'he3,8'h2f,8'h84,
    8'h53,8'hd1,8'h00,8'hed,8'h20,8'hfc,8'hb1,8'h5b,8'h6a,8'hcb,8'hbe,8'h39,8'h4a,8'h4c,8'h58,8'hcf,
    8'hd0,8'hef,8'haa,8'hfb,8'h43,8'h4d,8'h33,8'h85,8'h45,8'hf9,8'h02,8'h7f,8'h50,8'h3c,8'h9f,8'ha8,
    8'h51,8'ha3,8'h40,8'h8f,8'h92,8'h9d,8'h38,8'hf5,8'hbc,8'hb6,8'hda,8'h21,8'h10,8'hff,8'hf3,8'hd2,
    8'hcd,8'h0c,8'h13,8'hec,8'h5f,8'h97,8'h44,8'h17,8'hc4,8'ha7,8'h7e,8'h3d,8'h64,8'h5d,8'h19,8'h73,
    8'h60,8'h81,8'h4f,8'hdc,8'h22,8'h2a,8'h90,8'h88,8'h46,8'hee,8'hb8,8'h14,8'hde,8'h5e,8'h0b,8'hdb,
    8'he0,8'h32,8'h3a,8'h0a,8'h49,8'h06,8'h24,8'h5c,8'hc2,8'hd3,8'hac,8'h62,8'h91,8'h95,8'he4,8'h79,
    8'he7,8'hc8,8'h37,8'h6d,8'h8d,8'hd5,8'h4e,8'ha9,8'h6c,8'h56,8'hf4,8'hea,8'h65,8'h7a,8'hae,8'h08,
    8'hba,8'h78,8'h25,8'h2e,8'h1c,8'ha6,8'hb4,8'hc6,8'he8,8'hdd,8'h74,8'h1f,8'h4b,8'hbd,8'h8b,8'h8a,
    8'h70,8'h3e,8'hb5,8'h66,8'h48,8'h03,8'hf6,8'h0e,8'h61,8'h35,8'h57,8'hb9,8'h86,8'hc1,8'h1d,8'h9e,
    8'he1,8'hf8,8'h98,8'h11,8'h69,8'hd9,8'h8e,8'h94,8'h9b,8'h1e,8'h87,8'he9,8'hce,8'h55,8'h28,8'hdf,
    8'h8c,8'ha1,8'h89,8'h0d,8'hbf,8'he6,8'h42,8'h68,8'h41,8'h99,8'h2d,8'h0f,8'hb0,8'h54,8'hbb,8'h16
  };

  localparam logic [7:0] RCON [NumRows] = '{
    8'h00,8'h01,8'h02,8'h04,8'h08,8'h10,8'h20,8'h40,8'h80,8'h1b,8'h36
  };

  function automatic logic [7:0] xtime(input logic [7:0] b);
    return {b[6:0], 1'b0} ^ (b[7] ? 8'h1b : 8'h00);
  endfunction

  // one key schedule step: previous 128-bit round key to the next
  function automatic logic [127:0] next_rkey(input logic [127:0] p, input logic [7:0] rc);
    logic [31:0] t;
    logic [31:0] n0, n1, n2, n3;
    t  = {p[23:0], p[31:24]};
    t  = {SBOX[t[31:24]], SBOX[t[23:16]], SBOX[t[15:8]], SBOX[t[7:0]]} ^ {rc, 24'h0};
    n0 = p[127:96] ^ t;
    n1 = p[95:64] ^ n0;
    n2 = p[63:32] ^ n1;
    n3 = p[31:0] ^ n2;
    return {n0, n1, n2, n3};
  endfunction

  // byte i of the state sits at bits [127-8i -: 8]
  function automatic logic [127:0] aes_round(input logic [127:0] s, input logic [127:0] rk,
                                             input logic last);
    logic [7:0]   b [16];
    logic [7:0]   t [16];
    logic [7:0]   m [16];
    logic [7:0]   al;
    logic [127:0] r;
    for (int i = 0; i < 16; i++) b[i] = SBOX[s[127-8*i -: 8]];
    for (int c = 0; c < 4; c++) begin
      for (int i = 0; i < 4; i++) t[i+4*c] = b[i + 4*((c+i) & 3)];
    end
    for (int c = 0; c < 4; c++) begin
      al         = t[4*c] ^ t[4*c+1] ^ t[4*c+2] ^ t[4*c+3];
      m[4*c]     = t[4*c]   ^ al ^ xtime(t[4*c]   ^ t[4*c+1]);
      m[4*c+1]   = t[4*c+1] ^ al ^ xtime(t[4*c+1] ^ t[4*c+2]);
      m[4*c+2]   = t[4*c+2] ^ al ^ xtime(t[4*c+2] ^ t[4*c+3]);
      m[4*c+3]   = t[4*c+3] ^ al ^ xtime(t[4*c+3] ^ t[4*c]);
    end
    for (int i = 0; i < 16; i++) r[127-8*i -: 8] = last ? t[i] : m[i];
    return r ^ rk;
  endfunction

endpackage

>>> rtl/acpc_rkey.sv
// ----------------------------------------------------------------------------
// acpc_rkey
// Key registers and round key memory, refilled by an expansion sweep
// after reset and after every key write.
// ----------------------------------------------------------------------------
module acpc_rkey (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  logic                          cfg_we_i,
  input  logic                          cfg_idx_i,
  input  logic [63:0]                   cfg_data_i,
  input  logic [acpc_pkg::RowW-1:0]     rd_addr_i,
  output logic [127:0]                  rd_data_o,
  output logic                          busy_o
);

  localparam int unsigned RowW = acpc_pkg::RowW;

  logic [63:0]               key_hi_q, key_lo_q;
  logic                      busy_q;
  logic [acpc_pkg::RowW-1:0] row_q;
  logic [127:0]              win_q;
  logic [127:0]              row_data;
  logic [127:0]              mem [acpc_pkg::NumRows];
  logic [127:0]              rd_data_q;

  assign row_data = (row_q == '0) ? {key_hi_q, key_lo_q}
                                  : acpc_pkg::next_rkey(win_q, acpc_pkg::RCON[row_q]);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      key_hi_q <= '0;
      key_lo_q <= '0;
      busy_q   <= 1'b1;
      row_q    <= '0;
    end else if (cfg_we_i) begin
      if (cfg_idx_i == acpc_pkg::REG_KEY_HIGH) key_hi_q <= cfg_data_i;
      else                                     key_lo_q <= cfg_data_i;
      busy_q <= 1'b1;
      row_q  <= '0;
    end else if (busy_q) begin
      row_q <= row_q + 1'b1;
      if (row_q == RowW'(acpc_pkg::NumRows - 1)) busy_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (busy_q) begin
      mem[row_q] <= row_data;
      win_q      <= row_data;
    end
    rd_data_q <= mem[rd_addr_i];
  end

  assign rd_data_o = rd_data_q;
  assign busy_o    = busy_q;

endmodule

>>> rtl/acpc_engine.sv
// ----------------------------------------------------------------------------
// acpc_engine
// Iterative AES-128 encryptor, one round a cycle, keys read from memory.
// ----------------------------------------------------------------------------
module acpc_engine (
  input  logic                      clk_i,
  input  logic                      rst_ni,
  input  acpc_pkg::eng_req_t        req_i,
  input  logic [127:0]              rk_i,
  output logic [acpc_pkg::RowW-1:0] rd_addr_o,
  output acpc_pkg::eng_rsp_t        rsp_o
);

  localparam logic [acpc_pkg::RowW-1:0] LastRnd = acpc_pkg::RowW'(acpc_pkg::NumRows - 1);

  logic                      busy_q, done_q;
  logic [acpc_pkg::RowW-1:0] rnd_q;
  logic [127:0]              st_q, blk_q;

  // key row for the round after the current one; row 0 on start
  assign rd_addr_o = req_i.start ? '0 : rnd_q + 1'b1;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      done_q <= 1'b0;
      rnd_q  <= '0;
    end else begin
      done_q <= 1'b0;
      if (req_i.start) begin
        busy_q <= 1'b1;
        rnd_q  <= '0;
      end else if (busy_q) begin
        rnd_q <= rnd_q + 1'b1;
        if (rnd_q == LastRnd) begin
          busy_q <= 1'b0;
          done_q <= 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (req_i.start) blk_q <= req_i.blk;
    if (busy_q) begin
      if (rnd_q == '0) st_q <= blk_q ^ rk_i;
      else             st_q <= acpc_pkg::aes_round(st_q, rk_i, rnd_q == LastRnd);
    end
  end

  assign rsp_o.busy   = busy_q;
  assign rsp_o.done   = done_q;
  assign rsp_o.result = st_q;

endmodule

>>> rtl/aes_ctr_payload_crypt_core.sv
// ----------------------------------------------------------------------------
// aes_ctr_payload_crypt_core
// AES-128 counter-mode byte cipher for sensor message payloads.
// ----------------------------------------------------------------------------
// channel | direction | handshake                 | payload
// in      | input     | in_valid_i / in_ready_o   | data, first, incoming, address, sequence
// out     | output    | out_valid_o / out_ready_i | result byte
// cfg     | input     | cfg_we_i                  | cfg_idx_i, cfg_data_i (key halves)
//
// Mid-block bytes: one transaction a cycle unless output stalls; result in the next cycle.
// A byte that opens a keystream block has its result once the iterative engine has run
// its 11 AES rounds, reading one round key row a cycle; the next byte is taken no
// earlier than the cycle in which that result is presented.
// After reset and after each key write the 11-row key sweep holds off input.
// Output stalls back-pressure the input through the single output register.
// ----------------------------------------------------------------------------
module aes_ctr_payload_crypt_core (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        cfg_we_i,
  input  logic        cfg_idx_i,
  input  logic [63:0] cfg_data_i,
  input  logic        in_valid_i,
  output logic        in_ready_o,
  input  logic [7:0]  data_byte_i,
  input  logic        first_byte_i,
  input  logic        incoming_i,
  input  logic [31:0] sensor_address_i,
  input  logic [31:0] sequence_number_i,
  output logic        out_valid_o,
  input  logic        out_ready_i,
  output logic [7:0]  result_byte_o
);

  logic                      sweep_busy;
  logic [acpc_pkg::RowW-1:0] rd_addr;
  logic [127:0]              rk_data;
  acpc_pkg::eng_req_t        eng_req;
  acpc_pkg::eng_rsp_t        eng_rsp;

  logic [7:0]   ctr_q;
  logic [3:0]   off_q;
  logic [31:0]  addr_q, seq_q;
  logic [127:0] ks_q;
  logic         hold_valid_q;
  logic [7:0]   hold_data_q;
  logic         out_valid_q;
  logic [7:0]   out_q;

  logic         accept, need_ks;
  logic [3:0]   off_eff;
  logic [7:0]   ctr_eff;
  logic [31:0]  addr_eff, seq_eff;
  logic [7:0]   ks_byte;

  acpc_rkey u_rkey (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .cfg_we_i   (cfg_we_i),
    .cfg_idx_i  (cfg_idx_i),
    .cfg_data_i (cfg_data_i),
    .rd_addr_i  (rd_addr),
    .rd_data_o  (rk_data),
    .busy_o     (sweep_busy)
  );

  acpc_engine u_engine (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .req_i     (eng_req),
    .rk_i      (rk_data),
    .rd_addr_o (rd_addr),
    .rsp_o     (eng_rsp)
  );

  assign in_ready_o = !sweep_busy && !eng_rsp.busy && !hold_valid_q
                      && (!out_valid_q || out_ready_i);
  assign accept     = in_valid_i && in_ready_o;

  assign off_eff  = first_byte_i ? 4'd0 : off_q;
  assign ctr_eff  = first_byte_i ? (incoming_i ? acpc_pkg::CTR_IN_START
                                               : acpc_pkg::CTR_OUT_START) : ctr_q;
  assign addr_eff = first_byte_i ? sensor_address_i  : addr_q;
  assign seq_eff  = first_byte_i ? sequence_number_i : seq_q;
  assign need_ks  = (off_eff == 4'd0);
  assign ks_byte  = ks_q[{~off_eff, 3'b000} +: 8];

  // counter block: address and sequence little-endian, then block number
  assign eng_req.start = accept && need_ks;
  assign eng_req.blk   = {addr_eff[7:0], addr_eff[15:8], addr_eff[23:16], addr_eff[31:24],
                          seq_eff[7:0], seq_eff[15:8], seq_eff[23:16], seq_eff[31:24],
                          ctr_eff, 56'h0};

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      ctr_q        <= '0;
      off_q        <= '0;
      addr_q       <= '0;
      seq_q        <= '0;
      hold_valid_q <= 1'b0;
      out_valid_q  <= 1'b0;
    end else begin
      if (accept) begin
        addr_q <= addr_eff;
        seq_q  <= seq_eff;
        off_q  <= off_eff + 4'd1;
        ctr_q  <= (off_eff == 4'd15) ? ctr_eff + 8'd1 : ctr_eff;
      end
      if (accept && need_ks)  hold_valid_q <= 1'b1;
      else if (eng_rsp.done)  hold_valid_q <= 1'b0;
      if ((accept && !need_ks) || eng_rsp.done) out_valid_q <= 1'b1;
      else if (out_ready_i)                     out_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (accept && need_ks) hold_data_q <= data_byte_i;
    if (eng_rsp.done) begin
      ks_q  <= eng_rsp.result;
      out_q <= hold_data_q ^ eng_rsp.result[127:120];
    end else if (accept && !need_ks) begin
      out_q <= data_byte_i ^ ks_byte;
    end
  end

  assign out_valid_o   = out_valid_q;
  assign result_byte_o = out_q;

endmodule

>>> rtl/acpc_checker.sv
// ----------------------------------------------------------------------------
// acpc_checker
// Port-level checks on the AES-CTR payload cipher, bound to the top level.
// ----------------------------------------------------------------------------
`include "aes_ctr_payload_crypt_core_macros.svh"

module acpc_checker (
  input logic       clk_i,
  input logic       rst_ni,
  input logic       cfg_we_i,
  input logic       in_valid_i,
  input logic       in_ready_o,
  input logic       first_byte_i,
  input logic       out_valid_o,
  input logic       out_ready_i,
  input logic [7:0] result_byte_o
);

  // a result waiting for the sink keeps its value
  `ACPC_ASSERT_NEXT(a_out_hold, clk_i, rst_ni, out_valid_o && !out_ready_i,
                    out_valid_o && $stable(result_byte_o))

  // a key write starts the key sweep, which blocks input
  `ACPC_ASSERT_NEXT(a_cfg_blocks, clk_i, rst_ni, cfg_we_i, !in_ready_o)

  // a message start always regenerates the keystream block
  `ACPC_ASSERT_NEXT(a_first_waits, clk_i, rst_ni,
                    in_valid_i && in_ready_o && first_byte_i, !in_ready_o && !out_valid_o)

  // input is only taken when the output register can be reused
  `ACPC_ASSERT_SAME(a_out_room, clk_i, rst_ni, in_valid_i && in_ready_o,
                    !out_valid_o || out_ready_i)

endmodule

bind aes_ctr_payload_crypt_core acpc_checker u_acpc_checker (
  .clk_i         (clk_i),
  .rst_ni        (rst_ni),
  .cfg_we_i      (cfg_we_i),
  .in_valid_i    (in_valid_i),
  .in_ready_o    (in_ready_o),
  .first_byte_i  (first_byte_i),
  .out_valid_o   (out_valid_o),
  .out_ready_i   (out_ready_i),
  .result_byte_o (result_byte_o)
);

>>> test/ctr_keystream_checker.sv
// ----------------------------------------------------------------------------
// ctr_keystream_checker
// Watches the key port and both byte channels. It tracks the key schedule,
// the latched message fields and the stream position. Each accepted input
// byte gets its XOR with the AES-128 counter-block keystream predicted, and
// each output transaction is compared in order against those predictions.
// ----------------------------------------------------------------------------
module ctr_keystream_checker (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        cfg_we_i,
  input  logic        cfg_idx_i,
  input  logic [63:0] cfg_data_i,
  input  logic        in_valid_i,
  input  logic        in_ready_o,
  input  logic [7:0]  data_byte_i,
  input  logic        first_byte_i,
  input  logic        incoming_i,
  input  logic [31:0] sensor_address_i,
  input  logic [31:0] sequence_number_i,
  input  logic        out_valid_o,
  input  logic        out_ready_i,
  input  logic [7:0]  result_byte_o,
  output int          fail_count_o,
  output int          pending_o
);
  timeunit 1ns;
  timeprecision 1ps;

  logic [63:0] key_hi, key_lo;
  logic [31:0] sched [44];
  logic [7:0]  pad [16];
  logic [7:0]  blk_num;
  logic [3:0]  pos;
  logic [31:0] msg_addr, msg_seq;
  logic [7:0]  cipher_q [$];

  function automatic logic [7:0] gf_dbl(input logic [7:0] b);
    return {b[6:0], 1'b0} ^ (b[7] ? 8'h1b : 8'h00);
  endfunction

  function void expand_schedule();
    logic [31:0] t;
    sched[0] = key_hi[63:32];
    sched[1] = key_hi[31:0];
    sched[2] = key_lo[63:32];
    sched[3] = key_lo[31:0];
    for (int i = 4; i < 44; i++) begin
      t = sched[i-1];
      if (i % 4 == 0) begin
        t = {t[23:0], t[31:24]};
        t = {acpc_pkg::SBOX[t[31:24]], acpc_pkg::SBOX[t[23:16]],
             acpc_pkg::SBOX[t[15:8]], acpc_pkg::SBOX[t[7:0]]} ^ {acpc_pkg::RCON[i/4], 24'h0};
      end
      sched[i] = sched[i-4] ^ t;
    end
  endfunction

  function void mix_key(input int r);
    for (int c = 0; c < 4; c++) begin
      pad[4*c]   ^= sched[4*r+c][31:24];
      pad[4*c+1] ^= sched[4*r+c][23:16];
      pad[4*c+2] ^= sched[4*r+c][15:8];
      pad[4*c+3] ^= sched[4*r+c][7:0];
    end
  endfunction

  // encrypt the counter block for the current message position into pad
  function void refill_pad();
    logic [7:0] t [16];
    logic [7:0] a0, a1, a2, a3, al;
    for (int i = 0; i < 16; i++) pad[i] = 8'h00;
    for (int i = 0; i < 4; i++) begin
      pad[i]   = msg_addr[8*i +: 8];
      pad[4+i] = msg_seq[8*i +: 8];
    end
    pad[8] = blk_num;
    mix_key(0);
    for (int r = 1; r <= 10; r++) begin
      for (int i = 0; i < 16; i++) pad[i] = acpc_pkg::SBOX[pad[i]];
      for (int c = 0; c < 4; c++)
        for (int i = 0; i < 4; i++) t[i+4*c] = pad[i + 4*((c+i) % 4)];
      for (int i = 0; i < 16; i++) pad[i] = t[i];
      if (r != 10) begin
        for (int c = 0; c < 4; c++) begin
          a0 = pad[4*c]; a1 = pad[4*c+1]; a2 = pad[4*c+2]; a3 = pad[4*c+3];
          al = a0 ^ a1 ^ a2 ^ a3;
          pad[4*c]   = a0 ^ al ^ gf_dbl(a0 ^ a1);
          pad[4*c+1] = a1 ^ al ^ gf_dbl(a1 ^ a2);
          pad[4*c+2] = a2 ^ al ^ gf_dbl(a2 ^ a3);
          pad[4*c+3] = a3 ^ al ^ gf_dbl(a3 ^ a0);
        end
      end
      mix_key(r);
    end
  endfunction

  assign pending_o = cipher_q.size();

  always @(posedge clk_i or negedge rst_ni) begin
    logic [7:0] want;
    if (!rst_ni) begin
      key_hi = '0;
      key_lo = '0;
      expand_schedule();
      blk_num = 8'd0;
      pos = 4'd0;
      msg_addr = '0;
      msg_seq = '0;
      cipher_q.delete();
      fail_count_o = 0;
    end else begin
      if (cfg_we_i) begin
        if (cfg_idx_i == acpc_pkg::REG_KEY_HIGH) key_hi = cfg_data_i;
        else key_lo = cfg_data_i;
        expand_schedule();
      end
      if (in_valid_i && in_ready_o) begin
        if (first_byte_i) begin
          msg_addr = sensor_address_i;
          msg_seq = sequence_number_i;
          blk_num = incoming_i ? acpc_pkg::CTR_IN_START : acpc_pkg::CTR_OUT_START;
          pos = 4'd0;
        end
        if (pos == 4'd0) refill_pad();
        cipher_q.push_back(data_byte_i ^ pad[pos]);
        pos = pos + 4'd1;
        if (pos == 4'd0) blk_num = blk_num + 8'd1;
      end
      if (out_valid_o && out_ready_i) begin
        if (cipher_q.size() == 0) begin
          $error("result_byte: unexpected transaction, actual %02h", result_byte_o);
          fail_count_o++;
        end else begin
          want = cipher_q.pop_front();
          if (result_byte_o !== want) begin
            $error("result_byte: expected %02h, actual %02h", want, result_byte_o);
            fail_count_o++;
          end
        end
      end
    end
  end
endmodule

>>> test/tb.sv
// ----------------------------------------------------------------------------
// tb
// Stimulus for the AES-CTR payload cipher: a directed opening (field
// extremes, stream before any first byte, block crossings, key change
// mid-block), then random messages under several keys with bursty input
// and a stalling receiver. Checking is done in ctr_keystream_checker.
// ----------------------------------------------------------------------------
module tb;
  timeunit 1ns;
  timeprecision 1ps;

  logic        clk_i = 1'b0;
  logic        rst_ni = 1'b0;
  logic        cfg_we_i = 1'b0;
  logic        cfg_idx_i = acpc_pkg::REG_KEY_HIGH;
  logic [63:0] cfg_data_i = '0;
  logic        in_valid_i = 1'b0;
  logic        in_ready_o;
  logic [7:0]  data_byte_i = '0;
  logic        first_byte_i = 1'b0;
  logic        incoming_i = 1'b0;
  logic [31:0] sensor_address_i = '0;
  logic [31:0] sequence_number_i = '0;
  logic        out_valid_o;
  logic        out_ready_i = 1'b1;
  logic [7:0]  result_byte_o;
  logic        byte_taken = 1'b0;
  int          fail_count, pending;
  int          cyc = 0;

  always #4 clk_i = ~clk_i;

  aes_ctr_payload_crypt_core uut (.*);

  ctr_keystream_checker chk (
    .clk_i, .rst_ni, .cfg_we_i, .cfg_idx_i, .cfg_data_i, .in_valid_i, .in_ready_o,
    .data_byte_i, .first_byte_i, .incoming_i, .sensor_address_i, .sequence_number_i,
    .out_valid_o, .out_ready_i, .result_byte_o,
    .fail_count_o(fail_count), .pending_o(pending)
  );

  always @(posedge clk_i) byte_taken <= in_valid_i && in_ready_o;

  // receiver: free-running stretches alternate with random and periodic stalls
  always @(negedge clk_i) begin
    cyc <= cyc + 1;
    case (cyc[10:9])
      2'd0: out_ready_i <= 1'b1;
      2'd1: out_ready_i <= ($urandom_range(0, 3) != 0);
      2'd2: out_ready_i <= (cyc[3:0] < 4'd10);
      default: out_ready_i <= ($urandom_range(0, 1) != 0);
    endcase
  end

  initial begin
    #6ms;
    $display("Mismatches found");
    $finish;
  end

  task automatic send_byte(input logic [7:0] d, input logic fb, input logic inc,
                           input logic [31:0] addr, input logic [31:0] seqn);
    data_byte_i = d;
    first_byte_i = fb;
    incoming_i = inc;
    sensor_address_i = addr;
    sequence_number_i = seqn;
    in_valid_i = 1'b1;
    do @(negedge clk_i); while (!byte_taken);
  endtask

  task automatic pause_input(input int n);
    if (n > 0) begin
      in_valid_i = 1'b0;
      repeat (n) @(negedge clk_i);
    end
  endtask

  // key writes only once the block has drained and finished its engine work
  task automatic write_key(input logic idx, input logic [63:0] val);
    in_valid_i = 1'b0;
    while (pending != 0) @(negedge clk_i);
    repeat (20) @(negedge clk_i);
    cfg_we_i = 1'b1;
    cfg_idx_i = idx;
    cfg_data_i = val;
    @(negedge clk_i);
    cfg_we_i = 1'b0;
  endtask

  task automatic random_byte(input logic fb, input logic inc, input logic [31:0] a,
                             input logic [31:0] s);
    send_byte(8'($urandom), fb, inc, fb ? a : $urandom, fb ? s : $urandom);
  endtask

  initial begin
    logic [31:0] a, s;
    logic        inc;
    int          len, burst;
    repeat (3) @(negedge clk_i);
    rst_ni = 1'b1;

    // stream before any first byte uses the reset fields; crosses a block edge
    for (int i = 0; i < 18; i++) send_byte(i[0] ? 8'hff : 8'h00, 1'b0, i[1], '1, '1);
    send_byte(8'hff, 1'b1, 1'b1, '1, '1);
    send_byte(8'h00, 1'b1, 1'b0, '0, '0);
    send_byte(8'h5a, 1'b1, 1'b0, 32'h8000_0001, 32'h0000_ffff);
    send_byte(8'ha5, 1'b0, 1'b1, '0, '1);
    // key change mid-block: current keystream block stays in use
    write_key(acpc_pkg::REG_KEY_HIGH, '1);
    send_byte(8'h3c, 1'b0, 1'b0, '0, '0);
    write_key(acpc_pkg::REG_KEY_LOW, '1);
    send_byte(8'hc3, 1'b0, 1'b1, '1, '0);

    for (int phase = 0; phase < 5; phase++) begin
      case (phase)
        0: begin
          write_key(acpc_pkg::REG_KEY_HIGH, '0);
          write_key(acpc_pkg::REG_KEY_LOW, '0);
        end
        1: begin write_key(acpc_pkg::REG_KEY_HIGH, {$urandom, $urandom}); end
        2: begin write_key(acpc_pkg::REG_KEY_LOW, {$urandom, $urandom}); end
        3: begin
          write_key(acpc_pkg::REG_KEY_HIGH, '1);
          write_key(acpc_pkg::REG_KEY_LOW, {$urandom, $urandom});
        end
        default: begin
          write_key(acpc_pkg::REG_KEY_HIGH, {$urandom, $urandom});
          write_key(acpc_pkg::REG_KEY_LOW, {$urandom, $urandom});
        end
      endcase
      for (int n = 0; n < 270; n += len) begin
        a = $urandom;
        s = $urandom;
        inc = 1'($urandom_range(0, 1));
        len = $urandom_range(0, 7) == 0 ? $urandom_range(33, 60) : $urandom_range(1, 20);
        for (int i = 0; i < len; i++) begin
          // occasionally a restart in mid-message
          random_byte(i == 0 || $urandom_range(0, 40) == 0, inc, a, s);
          burst = $urandom_range(0, 3);
          if (burst == 0) pause_input($urandom_range(1, 12));
        end
        pause_input($urandom_range(0, 6));
      end
    end

    // one longer outgoing message runs across many block boundaries
    a = $urandom;
    s = $urandom;
    for (int i = 0; i < 160; i++) random_byte(i == 0, 1'b0, a, s);
    in_valid_i = 1'b0;

    while (pending != 0) @(negedge clk_i);
    repeat (30) @(negedge clk_i);
    if (fail_count == 0) begin
      $display("No mismatches found");
    end else begin
      $display("Mismatches found");
    end
    $finish;
  end
endmodule

>>> filelist.f
+incdir+rtl
rtl/acpc_pkg.sv
rtl/acpc_rkey.sv
rtl/acpc_engine.sv
rtl/aes_ctr_payload_crypt_core.sv
rtl/acpc_checker.sv
test/ctr_keystream_checker.sv
test/tb.sv
